@@ hw/rtl/svm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types and constants of the saturating voice mixer.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int NUM_VOICES = 8;

  localparam logic [7:0]  VOICE_MASK      = 8'((1 << NUM_VOICES) - 1);
  localparam logic [10:0] MASTER_GAIN_MAX = 11'd1024;
  localparam logic [15:0] MIX_MAX         = 16'h7fff;
  localparam logic [15:0] MIX_MIN         = 16'h8000;

  // serial multiplier geometry
  localparam int MUL_A_W = 19;
  localparam int MUL_B_W = 16;
  localparam int SCALE_W = 20;
  localparam logic [4:0] GAIN_STEPS  = 5'd8;
  localparam logic [4:0] SCALE_STEPS = 5'd16;

  // configuration register indexes
  localparam logic [2:0] CFG_VOICE_GAIN  = 3'd0;
  localparam logic [2:0] CFG_MASTER_GAIN = 3'd1;
  localparam logic [2:0] CFG_MASTER_PAUSE = 3'd2;
  localparam logic [2:0] CFG_VOICE_PAUSE = 3'd3;

  // request function codes
  localparam logic [1:0] FUNC_SAMPLE   = 2'd0;
  localparam logic [1:0] FUNC_ATTACH   = 2'd1;
  localparam logic [1:0] FUNC_STOP     = 2'd2;
  localparam logic [1:0] FUNC_STOP_ALL = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GLOAD,
    S_GRUN,
    S_SLOAD,
    S_SRUN,
    S_ACC,
    S_EMIT
  } svm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } svm_mul_stat_t;

  typedef struct packed {
    logic add_en;
    logic finish;
    logic silent;
    logic neg;
  } svm_acc_ctrl_t;

endpackage

@@ hw/rtl/saturating_voice_mixer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_voice_mixer
// Mixes up to eight gain-scaled voices into one saturated 16-bit stream.
// ----------------------------------------------------------------------------
// usage:
//   in_ channel takes one request per voice sample or voice event; the
//   request flagged in_frame_last closes an output position and yields one
//   result on the out_ channel (mix and a flag that a voice contributed).
//   cfg_ channel writes gain table, master gain, master pause and pause mask;
//   write only while no request is in flight.
//   an eligible sample passes through a load state, a run in which the serial
//   multiplier forms voice gain times master gain, a second load state, a run
//   scaling the sample magnitude one bit per cycle, a state that adds and
//   saturates and a finish state, then the next request can be taken; a
//   closing result is registered from the finish state. events and skipped
//   samples go from acceptance straight to the finish state, which registers
//   their result. one request is worked at a time.
//   a closing request puts its result in the output register; the next
//   request is taken while that result waits. if the receiver stalls and a
//   second result is due, the block holds in its finish cycle until the
//   output register frees.
//   reset returns default gains, clears the mix and deactivates all voices.
// ----------------------------------------------------------------------------
module saturating_voice_mixer
  import svm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [2:0]         in_voice_number,
  input  logic signed [15:0] in_voice_sample,
  input  logic               in_source_done,
  input  logic               in_frame_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_mixed_sample,
  output logic               out_any_voice_mixed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  svm_state_t state_r, state_nxt;

  logic [63:0] voice_gain_r;
  logic [10:0] master_gain_r;
  logic        master_pause_r;
  logic [7:0]  voice_pause_r;
  logic [7:0]  active_r;

  logic [15:0] mag_r;
  logic        neg_r;
  logic [7:0]  vg_r;
  logic [10:0] mg_r;
  logic        last_r;

  logic        in_acc;
  logic        in_range;
  logic [7:0]  vbit;
  logic [7:0]  vg_sel;
  logic [10:0] mg_eff;
  logic        ok;
  logic        elig;

  logic               mul_start;
  logic [4:0]         mul_steps;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  svm_mul_stat_t      mul_stat;
  logic [MUL_A_W-1:0] prod_hi;
  logic [MUL_B_W-1:0] prod_lo;
  svm_acc_ctrl_t      acc_ctrl;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;

  assign in_range = {1'b0, in_voice_number} < 4'(NUM_VOICES);
  assign vbit     = in_range ? (8'd1 << in_voice_number) : 8'd0;
  assign vg_sel   = voice_gain_r[{in_voice_number, 3'b000} +: 8];
  assign mg_eff   = (master_gain_r > MASTER_GAIN_MAX) ? MASTER_GAIN_MAX : master_gain_r;
  assign ok       = (in_func == FUNC_SAMPLE) && in_range && !master_pause_r &&
                    (mg_eff != 11'd0) && ((active_r & vbit) != 8'd0) &&
                    ((voice_pause_r & vbit) == 8'd0) && (vg_sel != 8'd0);
  assign elig     = ok && !in_source_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_gain_r   <= 64'd4629771061636907072;
      master_gain_r  <= 11'd256;
      master_pause_r <= 1'b0;
      voice_pause_r  <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VOICE_GAIN:   voice_gain_r   <= cfg_data;
        CFG_MASTER_GAIN:  master_gain_r  <= cfg_data[10:0];
        CFG_MASTER_PAUSE: master_pause_r <= cfg_data[0];
        CFG_VOICE_PAUSE:  voice_pause_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // voice events and source-done take effect at acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (in_acc) begin
      case (in_func)
        FUNC_SAMPLE: begin
          if (ok && in_source_done) begin
            active_r <= active_r & ~vbit;
          end
        end
        FUNC_ATTACH:   active_r <= (active_r | vbit) & VOICE_MASK;
        FUNC_STOP:     active_r <= active_r & ~vbit;
        FUNC_STOP_ALL: active_r <= '0;
        default:       active_r <= active_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mag_r  <= in_voice_sample[15] ? (~in_voice_sample + 16'd1) : in_voice_sample;
      neg_r  <= in_voice_sample[15];
      vg_r   <= vg_sel;
      mg_r   <= mg_eff;
      last_r <= in_frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = elig ? S_GLOAD : S_EMIT;
        end
      end
      S_GLOAD: state_nxt = S_GRUN;
      S_GRUN: begin
        if (mul_stat.done) begin
          state_nxt = S_SLOAD;
        end
      end
      S_SLOAD: state_nxt = S_SRUN;
      S_SRUN: begin
        if (mul_stat.done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: state_nxt = S_EMIT;
      S_EMIT: begin
        if (!last_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = 1'b1;
    mul_start       = 1'b0;
    mul_steps       = GAIN_STEPS;
    mul_a           = {{(MUL_A_W-11){1'b0}}, mg_r};
    mul_b           = {{(MUL_B_W-8){1'b0}}, vg_r};
    acc_ctrl.add_en = 1'b0;
    acc_ctrl.finish = 1'b0;
    acc_ctrl.silent = master_pause_r || (mg_eff == 11'd0);
    acc_ctrl.neg    = neg_r;
    case (state_r)
      S_IDLE:  in_stall = 1'b0;
      S_GLOAD: mul_start = 1'b1;
      S_SLOAD: begin
        // gain product sits in prod_hi[10:0] and prod_lo[15:8] after eight steps
        mul_start = 1'b1;
        mul_steps = SCALE_STEPS;
        mul_a     = {prod_hi[10:0], prod_lo[15:8]};
        mul_b     = mag_r;
      end
      S_ACC:  acc_ctrl.add_en = 1'b1;
      S_EMIT: acc_ctrl.finish = last_r && out_free;
      default: ;
    endcase
  end

  svm_ser_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .steps   (mul_steps),
    .a_in    (mul_a),
    .b_in    (mul_b),
    .stat    (mul_stat),
    .prod_hi (prod_hi),
    .prod_lo (prod_lo)
  );

  // scaled magnitude is the product shifted down by 14
  svm_mix_acc u_acc (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctrl                (acc_ctrl),
    .scaled              ({prod_hi[17:0], prod_lo[15:14]}),
    .out_stall           (out_stall),
    .out_free            (out_free),
    .out_valid           (out_valid),
    .out_mixed_sample    (out_mixed_sample),
    .out_any_voice_mixed (out_any_voice_mixed)
  );

  a_mul_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.busy |-> (state_r == S_GRUN || state_r == S_SRUN))
    else $error("multiplier busy outside its run states");

  a_skip_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !elig) |=> (state_r == S_EMIT))
    else $error("skipped request did not go straight to finish");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_EMIT && last_r))
    else $error("result raised outside a closing request");

  a_pause_silent: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid) && $past(master_pause_r)) |->
      (out_mixed_sample == 16'sd0 && !out_any_voice_mixed))
    else $error("paused frame produced sound");

endmodule

@@ hw/rtl/svm_ser_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_ser_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module svm_ser_mul
  import svm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [4:0]           steps,
  input  logic [MUL_A_W-1:0]   a_in,
  input  logic [MUL_B_W-1:0]   b_in,
  output svm_mul_stat_t        stat,
  output logic [MUL_A_W-1:0]   prod_hi,
  output logic [MUL_B_W-1:0]   prod_lo
);

  logic [MUL_A_W-1:0] a_r;
  logic [MUL_A_W-1:0] hi_r;
  logic [MUL_B_W-1:0] lo_r;
  logic [4:0]         cnt_r;
  logic               busy_r;
  logic [MUL_A_W:0]   sum_nxt;

  assign sum_nxt = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  // product shifts right as the multiplier bits are consumed
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a_in;
      hi_r <= '0;
      lo_r <= b_in;
    end else if (busy_r) begin
      hi_r <= sum_nxt[MUL_A_W:1];
      lo_r <= {sum_nxt[0], lo_r[MUL_B_W-1:1]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == 5'd1);
  assign prod_hi   = hi_r;
  assign prod_lo   = lo_r;

endmodule

@@ hw/rtl/svm_mix_acc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_mix_acc
// Saturating running mix, contribution flag and result register.
// ----------------------------------------------------------------------------
module svm_mix_acc
  import svm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  svm_acc_ctrl_t        ctrl,
  input  logic [SCALE_W-1:0]   scaled,
  input  logic                 out_stall,
  output logic                 out_free,
  output logic                 out_valid,
  output logic signed [15:0]   out_mixed_sample,
  output logic                 out_any_voice_mixed
);

  logic [15:0]        mix_r;
  logic               contrib_r;
  logic               out_valid_r;
  logic [15:0]        mixed_r;
  logic               any_r;
  logic signed [21:0] term;
  logic signed [21:0] sum_nxt;
  logic [15:0]        mix_nxt;

  assign term    = ctrl.neg ? -$signed({2'b00, scaled}) : $signed({2'b00, scaled});
  assign sum_nxt = $signed({{6{mix_r[15]}}, mix_r}) + term;

  always_comb begin
    if (sum_nxt > $signed({{6{MIX_MAX[15]}}, MIX_MAX})) begin
      mix_nxt = MIX_MAX;
    end else if (sum_nxt < $signed({{6{MIX_MIN[15]}}, MIX_MIN})) begin
      mix_nxt = MIX_MIN;
    end else begin
      mix_nxt = sum_nxt[15:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r       <= '0;
      contrib_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.add_en) begin
        mix_r     <= mix_nxt;
        contrib_r <= 1'b1;
      end else if (ctrl.finish) begin
        mix_r     <= '0;
        contrib_r <= 1'b0;
      end
      if (ctrl.finish && !ctrl.add_en) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish && !ctrl.add_en) begin
      mixed_r <= ctrl.silent ? 16'h0000 : mix_r;
      any_r   <= ctrl.silent ? 1'b0 : contrib_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mixed_sample    = mixed_r;
  assign out_any_voice_mixed = any_r;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the saturating voice mixer: a queue-fed request
// driver, a result monitor with a scoreboard of predicted mixes, and
// register phases that sweep gains, pause bits and the master gain extremes.
// ----------------------------------------------------------------------------
module tb_top
  import svm_pkg::*;
();

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_COUNT = 11;
  localparam int PHASE_REQUESTS = 96;

  typedef struct {
    logic [1:0]         func;
    logic [2:0]         voice;
    logic signed [15:0] sample;
    logic               done;
    logic               last;
    int                 gap;
  } voice_req_t;

  typedef struct {
    logic signed [15:0] mix;
    logic               flag;
  } mix_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_func = FUNC_SAMPLE;
  logic [2:0]         in_voice_number = '0;
  logic signed [15:0] in_voice_sample = '0;
  logic               in_source_done = 1'b0;
  logic               in_frame_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_mixed_sample;
  logic               out_any_voice_mixed;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = CFG_VOICE_GAIN;
  logic [63:0]        cfg_data = '0;

  voice_req_t  request_q[$];
  mix_result_t pending_mixes[$];
  voice_req_t  cur_req;

  // register shadows
  logic [63:0] gain_tab = 64'h4040_4040_4040_4040;
  logic [10:0] master_gain_r = 11'd256;
  logic        master_pause_r = 1'b0;
  logic [7:0]  pause_mask_r = 8'h00;

  // mixer state as predicted
  int          run_mix = 0;
  logic [7:0]  voice_on = 8'h00;
  logic        mixed_any = 1'b0;

  bit calm = 1'b0;
  int faults = 0;
  int wait_cnt = 0;
  int hold = 0;
  int calm_out = 0;
  int quiet_cycles = 0;

  saturating_voice_mixer u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_voice_number     (in_voice_number),
    .in_voice_sample     (in_voice_sample),
    .in_source_done      (in_source_done),
    .in_frame_last       (in_frame_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_mixed_sample    (out_mixed_sample),
    .out_any_voice_mixed (out_any_voice_mixed),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sample times voice gain times master gain, Q2.6 * Q3.8, truncated toward zero
  function automatic int scaled_sample(logic signed [15:0] s, logic [7:0] g,
                                       logic [10:0] m);
    longint unsigned mag;
    longint unsigned prod;
    mag = (s < 0) ? longint'(-int'(s)) : longint'(int'(s));
    prod = (mag * g * m) >> 14;
    return (s < 0) ? -int'(prod) : int'(prod);
  endfunction

  task automatic advance_mix(input voice_req_t r);
    logic [7:0]  bit_v;
    logic [7:0]  vg;
    logic [10:0] mg;
    logic        eligible;
    int          acc;
    mix_result_t res;
    bit_v = 8'd1 << r.voice;
    vg = gain_tab[8*r.voice +: 8];
    mg = (master_gain_r > MASTER_GAIN_MAX) ? MASTER_GAIN_MAX : master_gain_r;
    case (r.func)
      FUNC_SAMPLE: begin
        eligible = !master_pause_r && mg != 0 && (voice_on & bit_v) != 0 &&
                   (pause_mask_r & bit_v) == 0 && vg != 0;
        if (eligible) begin
          if (r.done) begin
            voice_on &= ~bit_v;
          end else begin
            acc = run_mix + scaled_sample(r.sample, vg, mg);
            if (acc > $signed(MIX_MAX)) acc = $signed(MIX_MAX);
            if (acc < $signed(MIX_MIN)) acc = $signed(MIX_MIN);
            run_mix = acc;
            mixed_any = 1'b1;
          end
        end
      end
      FUNC_ATTACH: voice_on |= bit_v;
      FUNC_STOP: voice_on &= ~bit_v;
      FUNC_STOP_ALL: voice_on = '0;
      default: ;
    endcase
    voice_on &= VOICE_MASK;
    if (r.last) begin
      if (master_pause_r || mg == 0) begin
        res.mix = '0;
        res.flag = 1'b0;
      end else begin
        res.mix = 16'(run_mix);
        res.flag = mixed_any;
      end
      pending_mixes.push_back(res);
      run_mix = 0;
      mixed_any = 1'b0;
    end
  endtask

  task automatic push_req(input logic [1:0] f, input logic [2:0] v,
                          input logic [15:0] s, input logic d, input logic l);
    voice_req_t r;
    r.func = f;
    r.voice = v;
    r.sample = s;
    r.done = d;
    r.last = l;
    r.gap = calm ? 0 : $urandom_range(0, 19);
    request_q.push_back(r);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_VOICE_GAIN: gain_tab = val;
      CFG_MASTER_GAIN: master_gain_r = val[10:0];
      CFG_MASTER_PAUSE: master_pause_r = val[0];
      CFG_VOICE_PAUSE: pause_mask_r = val[7:0];
      default: ;
    endcase
  endtask

  // unused upper bits of the narrow registers carry junk
  task automatic set_mix_config(input logic [63:0] gt, input logic [10:0] mg,
                                input logic mp, input logic [7:0] vp);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(CFG_VOICE_GAIN, gt);
    write_reg(CFG_MASTER_GAIN, {junk[63:11], mg});
    write_reg(CFG_MASTER_PAUSE, {junk[63:1], mp});
    write_reg(CFG_VOICE_PAUSE, {junk[63:8], vp});
    @(negedge clk);
  endtask

  // block is idle once every request went in and every mix came out
  task automatic drain_requests();
    @(posedge clk);
    while (request_q.size() != 0 || in_valid || pending_mixes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_frames(input int n);
    logic [7:0]  pick;
    logic [2:0]  top_v;
    logic [15:0] s;
    while (request_q.size() < n) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // junk: any function, any order, stray frame ends
        repeat ($urandom_range(1, 6))
          push_req(2'($urandom), 3'($urandom), 16'($urandom),
                   1'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        repeat ($urandom_range(0, 2))
          push_req(FUNC_ATTACH, 3'($urandom), 16'($urandom), 1'($urandom), 1'b0);
        if ($urandom_range(0, 19) == 0)
          push_req(FUNC_STOP, 3'($urandom), 16'($urandom), 1'($urandom), 1'b0);
        if ($urandom_range(0, 49) == 0)
          push_req(FUNC_STOP_ALL, 3'($urandom), 16'($urandom), 1'($urandom), 1'b0);
        pick = 8'($urandom_range(1, 255));
        for (int v = 0; v < NUM_VOICES; v++)
          if (pick[v]) top_v = 3'(v);
        for (int v = 0; v < NUM_VOICES; v++) begin
          if (pick[v]) begin
            case ($urandom_range(0, 11))
              0: s = 16'h7fff;
              1: s = 16'h8000;
              2: s = 16'h0000;
              3: s = 16'hffff;
              default: s = 16'($urandom);
            endcase
            push_req(FUNC_SAMPLE, 3'(v), s, $urandom_range(0, 29) == 0,
                     3'(v) == top_v);
          end
        end
      end
    end
    calm = 1'b0;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      wait_cnt = 0;
    end else begin
      if (in_valid && !in_stall) advance_mix(cur_req);
      if (!in_valid || !in_stall) begin
        if (request_q.size() != 0 && wait_cnt >= request_q[0].gap) begin
          cur_req = request_q.pop_front();
          in_func <= cur_req.func;
          in_voice_number <= cur_req.voice;
          in_voice_sample <= cur_req.sample;
          in_source_done <= cur_req.done;
          in_frame_last <= cur_req.last;
          in_valid <= 1'b1;
          wait_cnt = 0;
        end else begin
          in_valid <= 1'b0;
          if (request_q.size() != 0) wait_cnt++;
        end
      end
    end
  end

  // result monitor and scoreboard
  always @(posedge clk) begin
    mix_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_mixes.size() == 0) begin
          $error("unexpected result: mixed_sample %0d any_voice_mixed %0b",
                 out_mixed_sample, out_any_voice_mixed);
          faults++;
        end else begin
          want = pending_mixes.pop_front();
          if (out_mixed_sample !== want.mix) begin
            $error("mixed_sample: expected %0d, actual %0d", want.mix, out_mixed_sample);
            faults++;
          end
          if (out_any_voice_mixed !== want.flag) begin
            $error("any_voice_mixed: expected %0b, actual %0b", want.flag,
                   out_any_voice_mixed);
            faults++;
          end
        end
        if (calm_out > 0) begin
          calm_out--;
          hold = 0;
        end else begin
          if ($urandom_range(0, 7) == 0) calm_out = $urandom_range(8, 30);
          hold = $urandom_range(0, 19);
        end
      end else if (hold > 0 && (out_valid || $urandom_range(0, 1) == 0)) begin
        hold--;
      end
      out_stall <= (hold > 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("saturating_voice_mixer: mismatch");
      $finish;
    end
  end

  initial begin
    logic [63:0] gt;
    logic [10:0] mg;
    logic        mp;
    logic [7:0]  vp;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default gains: both saturation rails, inactive voice, source done
    push_req(FUNC_ATTACH, 3'd0, 16'h0000, 1'b0, 1'b0);
    push_req(FUNC_ATTACH, 3'd1, 16'hffff, 1'b1, 1'b0);
    push_req(FUNC_ATTACH, 3'd7, 16'h0000, 1'b0, 1'b0);
    push_req(FUNC_SAMPLE, 3'd0, 16'h7fff, 1'b0, 1'b0);
    push_req(FUNC_SAMPLE, 3'd1, 16'h7fff, 1'b0, 1'b0);
    push_req(FUNC_SAMPLE, 3'd7, 16'h7fff, 1'b0, 1'b1);
    push_req(FUNC_SAMPLE, 3'd0, 16'h8000, 1'b0, 1'b0);
    push_req(FUNC_SAMPLE, 3'd7, 16'h8000, 1'b0, 1'b1);
    push_req(FUNC_SAMPLE, 3'd2, 16'h04d2, 1'b0, 1'b1);
    push_req(FUNC_SAMPLE, 3'd1, 16'hfffb, 1'b1, 1'b0);
    push_req(FUNC_SAMPLE, 3'd1, 16'h0309, 1'b0, 1'b0);
    push_req(FUNC_SAMPLE, 3'd0, 16'hffff, 1'b0, 1'b1);
    push_req(FUNC_STOP, 3'd7, 16'h0000, 1'b0, 1'b1);
    push_req(FUNC_STOP_ALL, 3'd5, 16'h0000, 1'b0, 1'b0);
    push_req(FUNC_ATTACH, 3'd3, 16'h0000, 1'b0, 1'b1);
    push_req(FUNC_SAMPLE, 3'd3, 16'h5555, 1'b1, 1'b1);
    drain_requests();

    // zero voice gain, paused voice, master gain above 4.0
    gt = 64'h4040_4040_4040_00ff;
    set_mix_config(gt, 11'h7ff, 1'b0, 8'h04);
    push_req(FUNC_ATTACH, 3'd0, 16'h0000, 1'b0, 1'b0);
    push_req(FUNC_ATTACH, 3'd1, 16'h0000, 1'b0, 1'b0);
    push_req(FUNC_ATTACH, 3'd2, 16'h0000, 1'b0, 1'b0);
    push_req(FUNC_SAMPLE, 3'd0, 16'h7fff, 1'b0, 1'b0);
    push_req(FUNC_SAMPLE, 3'd1, 16'h0100, 1'b1, 1'b0);
    push_req(FUNC_SAMPLE, 3'd2, 16'h1234, 1'b0, 1'b1);
    drain_requests();

    // zero master gain: silent, source done ignored
    set_mix_config(gt, 11'd0, 1'b0, 8'h00);
    push_req(FUNC_SAMPLE, 3'd0, 16'h7fff, 1'b1, 1'b1);
    drain_requests();

    set_mix_config(gt, 11'd1, 1'b1, 8'h00);
    push_req(FUNC_SAMPLE, 3'd0, 16'h03e8, 1'b0, 1'b1);
    drain_requests();

    // smallest master gain, negative full-scale sample, zero-gain voice closing the frame
    set_mix_config(gt, 11'd1, 1'b0, 8'h00);
    push_req(FUNC_SAMPLE, 3'd0, 16'h8000, 1'b0, 1'b0);
    push_req(FUNC_SAMPLE, 3'd1, 16'h7fff, 1'b0, 1'b1);
    drain_requests();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p % 4)
        0: begin
          gt = '1;
          mg = MASTER_GAIN_MAX;
        end
        1: begin
          gt = {$urandom, $urandom};
          mg = 11'($urandom_range(1, 2047));
        end
        2: begin
          for (int b = 0; b < 8; b++)
            gt[8*b +: 8] = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
          mg = ($urandom_range(0, 2) == 0) ? 11'd0 : 11'($urandom_range(1, 1023));
        end
        default: begin
          gt = (p % 8 == 3) ? 64'd0 : {$urandom, $urandom};
          mg = 11'h7ff;
        end
      endcase
      mp = (p == 5);
      vp = (p % 3 == 0) ? 8'h00 : ((p == PHASE_COUNT - 1) ? 8'hff : 8'($urandom));
      set_mix_config(gt, mg, mp, vp);
      queue_frames(PHASE_REQUESTS);
      drain_requests();
    end

    if (faults == 0)
      $display("saturating_voice_mixer: match");
    else
      $display("saturating_voice_mixer: mismatch");
    $finish;
  end

endmodule
